FILE: hdl/ppft_pkg.sv
package ppft_pkg;

	// Rotation stage count (default and the arctangent table length)
	localparam int ROTATION_STAGES = 16;
	localparam int TABLE_LEN = 24;

	// CORDIC gain 0.6072529350 as unsigned Q1.31
	localparam logic [31:0] GAIN_Q31 = 32'h4DBA76D4;

	// Arctangent of 2^-i in units of 2^32 per turn
	localparam logic [31:0] ATAN_TBL [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Direction codes
	localparam logic ACT_TO_LOCAL = 1'b0;
	localparam logic ACT_TO_WORLD = 1'b1;

	typedef struct packed {
		logic               action;
		logic signed [31:0] frame_x;
		logic signed [31:0] frame_y;
		logic [15:0]        frame_angle;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic [15:0]        pose_angle;
	} in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic [15:0]        out_angle;
		logic               saturated;
	} out_t;

endpackage

FILE: hdl/planar_pose_frame_transform_top.sv
// An accepted item passes the offset, gain, quadrant, CORDIC, rounding and clamp stages to rsp.
// One item per cycle while the output is not stalled; one CORDIC micro-rotation per pipeline stage.
// A stall at the output fills empty stages first, so bubbles collapse before req_stall rises.
// Reset clears every stage valid bit; payload registers are not reset.
module planar_pose_frame_transform_top #(
	parameter int ROTATION_STAGES = ppft_pkg::ROTATION_STAGES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ppft_pkg::in_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ppft_pkg::out_t rsp
);
	import ppft_pkg::*;

	localparam int N  = (ROTATION_STAGES < TABLE_LEN) ? ROTATION_STAGES : TABLE_LEN;
	localparam int NV = N + 5;
	localparam int CW = 52;
	localparam int RW = CW - 16;

	localparam logic signed [31:0] GAIN_S  = GAIN_Q31;
	localparam logic signed [RW:0] POS_LIM = (RW+1)'(64'sd2147483647);
	localparam logic signed [RW:0] NEG_LIM = -(RW+1)'(64'sd2147483648);

	typedef struct packed {
		logic               act;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic [15:0]        ang;
	} side_t;

	logic [NV-1:0] v_q;
	logic [NV-1:0] en;

	// Stage 1 registers
	logic signed [32:0] vx_s1, vy_s1;
	logic [1:0]         q_s1;
	logic [13:0]        r_s1;
	side_t              side_s1;

	// Stage 2 registers
	logic signed [63:0] prx_s2, pry_s2;
	logic [1:0]         q_s2;
	logic [13:0]        r_s2;
	side_t              side_s2;

	// CORDIC stage registers, index 0 is stage 3
	logic signed [CW-1:0] x_sc [N+1];
	logic signed [CW-1:0] y_sc [N+1];
	logic signed [31:0]   z_sc [N+1];
	side_t                side_sc [N+1];

	// Post stages
	logic signed [RW-1:0] rx_s4, ry_s4;
	side_t                side_s4;
	out_t                 out_s5;

	// Stage 1 combinational
	logic [15:0]        rot_a;
	logic signed [32:0] vx_d, vy_d;
	logic [15:0]        ang_d;

	// Stage 2 products
	logic signed [64:0] mul_x, mul_y;

	// Stage 3 rounding and quadrant swap
	logic signed [63:0]   rnd_x, rnd_y;
	logic signed [CW-1:0] px, py, qx, qy;

	// Stage 4 rounding and stage 5 add and clamp
	logic signed [CW-1:0] fin_x, fin_y;
	logic signed [RW:0]   sum_x, sum_y;
	logic                 sat_x, sat_y;
	logic signed [31:0]   cl_x, cl_y;

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		en[NV-1] = !v_q[NV-1] || !rsp_stall;
		for (int i = NV-2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	assign req_stall = !en[0];
	assign rsp_valid = v_q[NV-1];
	assign rsp       = out_s5;

	// Move valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < NV; i++) begin
				if (en[i]) begin
					v_q[i] <= (i == 0) ? req_valid : v_q[(i == 0) ? 0 : i-1];
				end
			end
		end
	end

	// Form the offset, rotation angle and output angle
	always_comb begin
		if (req.action == ACT_TO_WORLD) begin
			rot_a = req.frame_angle;
			vx_d  = 33'(req.pose_x);
			vy_d  = 33'(req.pose_y);
			ang_d = req.pose_angle + req.frame_angle;
		end else begin
			rot_a = 16'(16'd0 - req.frame_angle);
			vx_d  = 33'(req.pose_x) - 33'(req.frame_x);
			vy_d  = 33'(req.pose_y) - 33'(req.frame_y);
			ang_d = req.pose_angle - req.frame_angle;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			vx_s1       <= vx_d;
			vy_s1       <= vy_d;
			q_s1        <= rot_a[15:14] + {1'b0, rot_a[13]};
			r_s1        <= rot_a[13:0];
			side_s1.act <= req.action;
			side_s1.fx  <= req.frame_x;
			side_s1.fy  <= req.frame_y;
			side_s1.ang <= ang_d;
		end
	end

	// Apply the gain
	assign mul_x = vx_s1 * GAIN_S;
	assign mul_y = vy_s1 * GAIN_S;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prx_s2  <= mul_x[63:0];
			pry_s2  <= mul_y[63:0];
			q_s2    <= q_s1;
			r_s2    <= r_s1;
			side_s2 <= side_s1;
		end
	end

	// Round to Q20.32 and take out whole quarter turns
	always_comb begin
		rnd_x = (prx_s2 + 64'sd16384) >>> 15;
		rnd_y = (pry_s2 + 64'sd16384) >>> 15;
		px    = rnd_x[CW-1:0];
		py    = rnd_y[CW-1:0];
		case (q_s2)
			2'd0: begin
				qx = px;
				qy = py;
			end
			2'd1: begin
				qx = -py;
				qy = px;
			end
			2'd2: begin
				qx = -px;
				qy = -py;
			end
			default: begin
				qx = py;
				qy = -px;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			x_sc[0]    <= qx;
			y_sc[0]    <= qy;
			z_sc[0]    <= $signed({{2{r_s2[13]}}, r_s2, 16'h0000});
			side_sc[0] <= side_s2;
		end
	end

	// One micro-rotation per stage
	for (genvar k = 0; k < N; k++) begin : g_cordic
		logic signed [CW-1:0] dx, dy;
		logic signed [31:0]   at;

		assign dx = y_sc[k] >>> k;
		assign dy = x_sc[k] >>> k;
		assign at = ATAN_TBL[k];

		always_ff @(posedge clk) begin
			if (en[k+3]) begin
				if (!z_sc[k][31]) begin
					x_sc[k+1] <= x_sc[k] - dx;
					y_sc[k+1] <= y_sc[k] + dy;
					z_sc[k+1] <= z_sc[k] - at;
				end else begin
					x_sc[k+1] <= x_sc[k] + dx;
					y_sc[k+1] <= y_sc[k] - dy;
					z_sc[k+1] <= z_sc[k] + at;
				end
				side_sc[k+1] <= side_sc[k];
			end
		end
	end

	// Round back to Q20.16
	assign fin_x = (x_sc[N] + CW'(32768)) >>> 16;
	assign fin_y = (y_sc[N] + CW'(32768)) >>> 16;

	always_ff @(posedge clk) begin
		if (en[N+3]) begin
			rx_s4   <= fin_x[RW-1:0];
			ry_s4   <= fin_y[RW-1:0];
			side_s4 <= side_sc[N];
		end
	end

	// Add the frame origin for to-world items and clamp to 32 bits
	always_comb begin
		sum_x = (RW+1)'(rx_s4);
		sum_y = (RW+1)'(ry_s4);
		if (side_s4.act == ACT_TO_WORLD) begin
			sum_x = sum_x + (RW+1)'(side_s4.fx);
			sum_y = sum_y + (RW+1)'(side_s4.fy);
		end
		sat_x = (sum_x > POS_LIM) || (sum_x < NEG_LIM);
		sat_y = (sum_y > POS_LIM) || (sum_y < NEG_LIM);
		if (sum_x > POS_LIM) begin
			cl_x = 32'sh7FFFFFFF;
		end else if (sum_x < NEG_LIM) begin
			cl_x = 32'sh80000000;
		end else begin
			cl_x = sum_x[31:0];
		end
		if (sum_y > POS_LIM) begin
			cl_y = 32'sh7FFFFFFF;
		end else if (sum_y < NEG_LIM) begin
			cl_y = 32'sh80000000;
		end else begin
			cl_y = sum_y[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NV-1]) begin
			out_s5.out_x     <= cl_x;
			out_s5.out_y     <= cl_y;
			out_s5.out_angle <= side_s4.ang;
			out_s5.saturated <= sat_x || sat_y;
		end
	end

	// Stall the input only when the first stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> v_q[0])
		else $error("input stalled with an empty first stage");

	// Hold a stalled result in the output register
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NV-1] && rsp_stall |=> v_q[NV-1] && $stable(out_s5))
		else $error("stalled result lost or changed");

	// A clipped result sits on a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.saturated |->
			(rsp.out_x == 32'sh7FFFFFFF) || (rsp.out_x == 32'sh80000000) ||
			(rsp.out_y == 32'sh7FFFFFFF) || (rsp.out_y == 32'sh80000000))
		else $error("saturated flag without a clipped coordinate");

	// Keep the pipeline moving when the output is free
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_stall |-> !req_stall)
		else $error("input stalled while output is free");

endmodule

FILE: tb/sv/planar_pose_frame_transform_top_tb.sv
module planar_pose_frame_transform_top_tb;
	import ppft_pkg::*;

	localparam int RANDOM_ITEMS = 700;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 90;
	localparam logic signed [31:0] P_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] P_MIN = 32'sh80000000;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE,
		STALL_HOLD
	} stall_mode_e;

	// Predict each pose result and check the block's results in order
	class pose_scoreboard;
		out_t expected_q[$];
		int errors;
		int accepted;

		function new();
			errors = 0;
			accepted = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Rotate a Q16.16 vector counterclockwise by a binary angle
		function void rotate_vec(input longint vx, input longint vy, input logic [15:0] a,
			output longint ox, output longint oy);
			longint px, py, t, z, dx, dy;
			logic [1:0] q;
			int r;
			q = a[15:14];
			r = int'(a[13:0]);
			px = (vx * longint'(GAIN_Q31) + (longint'(1) << 14)) >>> 15;
			py = (vy * longint'(GAIN_Q31) + (longint'(1) << 14)) >>> 15;
			// fold the residue into [-1/8, 1/8) turn
			if (r >= 8192) begin
				q = q + 2'd1;
				r = r - 16384;
			end
			case (q)
				2'd1: begin
					t = px;
					px = -py;
					py = t;
				end
				2'd2: begin
					px = -px;
					py = -py;
				end
				2'd3: begin
					t = px;
					px = py;
					py = -t;
				end
				default: ;
			endcase
			z = longint'(r) * 65536;
			for (int i = 0; i < ROTATION_STAGES && i < TABLE_LEN; i++) begin
				dx = py >>> i;
				dy = px >>> i;
				if (z >= 0) begin
					px = px - dx;
					py = py + dy;
					z = z - longint'(ATAN_TBL[i]);
				end else begin
					px = px + dx;
					py = py - dy;
					z = z + longint'(ATAN_TBL[i]);
				end
			end
			ox = (px + 32768) >>> 16;
			oy = (py + 32768) >>> 16;
		endfunction

		function longint clip_pos(input longint v, inout bit sat);
			if (v > longint'(P_MAX)) begin
				sat = 1'b1;
				return longint'(P_MAX);
			end
			if (v < longint'(P_MIN)) begin
				sat = 1'b1;
				return longint'(P_MIN);
			end
			return v;
		endfunction

		function out_t predict_pose(in_t it);
			longint rx, ry;
			logic [15:0] back_angle;
			out_t res;
			bit sat;
			sat = 1'b0;
			back_angle = 16'd0 - it.frame_angle;
			if (it.action == ACT_TO_WORLD) begin
				rotate_vec(longint'(it.pose_x), longint'(it.pose_y), it.frame_angle, rx, ry);
				rx = rx + longint'(it.frame_x);
				ry = ry + longint'(it.frame_y);
				res.out_angle = it.pose_angle + it.frame_angle;
			end else begin
				// offset is formed wide so it never wraps
				rotate_vec(longint'(it.pose_x) - longint'(it.frame_x),
					longint'(it.pose_y) - longint'(it.frame_y), back_angle, rx, ry);
				res.out_angle = it.pose_angle - it.frame_angle;
			end
			rx = clip_pos(rx, sat);
			ry = clip_pos(ry, sat);
			res.out_x = rx[31:0];
			res.out_y = ry[31:0];
			res.saturated = sat;
			return res;
		endfunction

		function void note_request(in_t it);
			accepted++;
			expected_q.push_back(predict_pose(it));
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_response(out_t got);
			out_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with none pending: x=%0d y=%0d angle=%0d sat=%0b",
					got.out_x, got.out_y, got.out_angle, got.saturated));
				return;
			end
			want = expected_q.pop_front();
			if (got.out_x !== want.out_x)
				report($sformatf("out_x got %0d want %0d", got.out_x, want.out_x));
			if (got.out_y !== want.out_y)
				report($sformatf("out_y got %0d want %0d", got.out_y, want.out_y));
			if (got.out_angle !== want.out_angle)
				report($sformatf("out_angle got %0d want %0d", got.out_angle, want.out_angle));
			if (got.saturated !== want.saturated)
				report($sformatf("saturated got %0b want %0b", got.saturated, want.saturated));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	in_t req;
	logic rsp_valid;
	logic rsp_stall;
	out_t rsp;

	pose_scoreboard pose_board = new();
	stall_mode_e stall_mode;
	int stall_span;
	bit long_hold_done;
	int cycle_count;

	planar_pose_frame_transform_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Watch both channels for accepted items
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				pose_board.note_request(req);
			if (rsp_valid && !rsp_stall)
				pose_board.check_response(rsp);
		end
	end

	function automatic in_t make_item(logic act, logic signed [31:0] fx, logic signed [31:0] fy,
		logic [15:0] fa, logic signed [31:0] px, logic signed [31:0] py, logic [15:0] pa);
		in_t it;
		it.action = act;
		it.frame_x = fx;
		it.frame_y = fy;
		it.frame_angle = fa;
		it.pose_x = px;
		it.pose_y = py;
		it.pose_angle = pa;
		return it;
	endfunction

	// Mix full-range, moderate, small and near-limit positions
	function automatic logic signed [31:0] rand_pos();
		logic signed [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 3))
			0: return v;
			1: return v >>> 7;
			2: return v >>> 14;
			default: begin
				if ($urandom_range(0, 1))
					return P_MAX - $urandom_range(0, 255);
				return P_MIN + $urandom_range(0, 255);
			end
		endcase
	endfunction

	// Favor angles around the octant boundaries now and then
	function automatic logic [15:0] rand_angle();
		if ($urandom_range(0, 3) != 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 4) - 2);
	endfunction

	function automatic in_t random_item();
		return make_item(logic'($urandom_range(0, 1)), rand_pos(), rand_pos(), rand_angle(),
			rand_pos(), rand_pos(), rand_angle());
	endfunction

	// Offer one item and hold it until accepted
	task automatic send_item(in_t it);
		@(negedge clk);
		req_valid <= 1'b1;
		req <= it;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	task automatic idle(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		while (pose_board.pending() != 0)
			@(negedge clk);
	endtask

	// Receiver stall pattern, with one long hold once traffic is flowing
	initial begin
		rsp_stall = 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			stall_mode = stall_mode_e'($urandom_range(0, 3));
			stall_span = $urandom_range(10, 150);
			if (!long_hold_done && pose_board.accepted >= 200) begin
				stall_mode = STALL_HOLD;
				stall_span = HOLD_CYCLES;
				long_hold_done = 1'b1;
			end
			for (int k = 0; k < stall_span; k++) begin
				@(negedge clk);
				case (stall_mode)
					STALL_NONE: rsp_stall <= 1'b0;
					STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
					STALL_TOGGLE: rsp_stall <= k[0];
					default: rsp_stall <= 1'b1;
				endcase
			end
		end
	end

	// Bound the run
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Main stimulus
	initial begin
		int sent;
		int burst;
		int gap;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// identity, zero and quarter-turn rotations
		send_item(make_item(ACT_TO_LOCAL, 0, 0, 0, 0, 0, 0));
		send_item(make_item(ACT_TO_WORLD, 0, 0, 0, 0, 0, 0));
		send_item(make_item(ACT_TO_LOCAL, 0, 0, 0, 32'sh10000, 0, 0));
		send_item(make_item(ACT_TO_WORLD, 0, 0, 16'd16384, 32'sh10000, 0, 16'd100));
		send_item(make_item(ACT_TO_WORLD, 0, 0, 16'd32768, 32'sh10000, 32'sh20000, 0));
		send_item(make_item(ACT_TO_WORLD, 0, 0, 16'd49152, 32'sh10000, 32'sh20000, 0));
		// residue on either side of the octant fold
		send_item(make_item(ACT_TO_WORLD, 0, 0, 16'd8191, 32'sh50000, 32'sh50000, 0));
		send_item(make_item(ACT_TO_WORLD, 0, 0, 16'd8192, 32'sh50000, 32'sh50000, 0));
		// heading wrap in both directions
		send_item(make_item(ACT_TO_LOCAL, 32'sh30000, -32'sh30000, 16'd65535, 0, 0, 0));
		send_item(make_item(ACT_TO_WORLD, 32'sh30000, -32'sh30000, 16'd65535, 0, 0, 16'd65535));
		// offset wider than 32 bits and position clipping
		send_item(make_item(ACT_TO_LOCAL, P_MIN, P_MAX, 0, P_MAX, P_MIN, 0));
		send_item(make_item(ACT_TO_LOCAL, P_MIN, 0, 16'd32768, P_MAX, 0, 16'd1));
		send_item(make_item(ACT_TO_WORLD, P_MAX, P_MAX, 0, P_MAX, P_MAX, 0));
		send_item(make_item(ACT_TO_WORLD, P_MIN, P_MIN, 0, P_MIN, P_MIN, 0));
		send_item(make_item(ACT_TO_WORLD, 0, 0, 16'd32768, P_MIN, P_MIN, 0));
		send_item(make_item(ACT_TO_WORLD, P_MIN, P_MAX, 16'd8192, P_MAX, P_MIN, 16'd8192));
		// alternating and all-ones bit patterns
		send_item(make_item(ACT_TO_LOCAL, -1, -1, 16'd24576, -1, -1, 16'd40000));
		send_item(make_item(ACT_TO_WORLD, 32'shAAAAAAAA, 32'sh55555555, 16'h5555,
			32'sh55555555, 32'shAAAAAAAA, 16'hAAAA));
		send_item(make_item(ACT_TO_LOCAL, 32'sh55555555, 32'shAAAAAAAA, 16'hAAAA,
			32'shAAAAAAAA, 32'sh55555555, 16'h5555));
		// tiny vectors exercise the rounding
		send_item(make_item(ACT_TO_WORLD, 0, 0, 16'd4096, 1, -1, 0));
		send_item(make_item(ACT_TO_LOCAL, 1, -1, 16'd61440, 0, 0, 16'd32768));
		idle(1);
		wait_drained();

		// random bursts with a full pause halfway
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
				send_item(random_item());
				sent++;
				if (sent == RANDOM_ITEMS / 2) begin
					idle(1);
					wait_drained();
				end
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			idle(gap);
		end
		idle(1);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (pose_board.errors == 0 && pose_board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
